### rtl/core/crt_pkg.sv
// shared types and constants for the confirmable retransmit table
package crt_pkg;
  localparam int SLOTS = 8;
  localparam int TIMER_BITS = 24;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [15:0] BASE_RESET = 16'd256;
  localparam logic [2:0] MAXRT_RESET = 3'd4;

  localparam logic [1:0] CMD_OPEN = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;
  localparam logic [1:0] CMD_LOOKUP = 2'd3;

  localparam logic [2:0] K_ONCE = 3'd0;
  localparam logic [2:0] K_KEPT = 3'd1;
  localparam logic [2:0] K_RESEND = 3'd2;
  localparam logic [2:0] K_GIVEUP = 3'd3;
  localparam logic [2:0] K_CLEARED = 3'd4;
  localparam logic [2:0] K_NOTFOUND = 3'd5;
  localparam logic [2:0] K_NOSLOT_FOUND = 3'd6;
  localparam logic [2:0] K_TICKDONE = 3'd7;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_MAXRT = 1'b1;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
    logic [SLOT_W-1:0] idx;
  } crt_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic hit;
  } crt_sts_t;

  function automatic logic [TIMER_BITS-1:0] arm_value(input logic [15:0] base,
                                                      input logic [2:0] att);
    logic [TIMER_BITS+22:0] v;
    v = {{(TIMER_BITS+7){1'b0}}, base} << att;
    if (v > {{23{1'b0}}, {TIMER_BITS{1'b1}}}) begin
      arm_value = {TIMER_BITS{1'b1}};
    end else begin
      arm_value = v[TIMER_BITS-1:0];
    end
  endfunction
endpackage

### rtl/core/crt_ctrl.sv
// controller sequencing one command over the table slots
module crt_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  crt_pkg::crt_sts_t sts,
  output crt_pkg::crt_cmd_t cmd
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [crt_pkg::SLOT_W-1:0] idx_r, idx_nxt;
  logic last_idx;

  assign last_idx = (idx_r == crt_pkg::SLOT_W'(crt_pkg::SLOTS - 1));
  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    cmd = '0;
    cmd.idx = idx_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          idx_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit && sts.cmd != crt_pkg::CMD_TICK) begin
          state_nxt = S_DONE;
        end else if (last_idx) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
    end
  end
endmodule

### rtl/core/crt_dp.sv
// datapath with slot table, registers and result formatting
module crt_dp (
  input  logic clk,
  input  logic rst_n,
  input  logic [1:0] in_command,
  input  logic [15:0] in_trans_id,
  input  logic in_confirmable,
  input  logic [15:0] base_timeout,
  input  logic [2:0] max_retransmit,
  input  crt_pkg::crt_cmd_t cmd,
  output crt_pkg::crt_sts_t sts,
  output logic out_valid,
  output logic [2:0] out_kind,
  output logic [2:0] out_slot,
  output logic [15:0] out_out_id,
  output logic [2:0] out_attempt,
  output logic out_last
);
  logic [crt_pkg::SLOTS-1:0] valid_r;
  logic [15:0] id_r [crt_pkg::SLOTS];
  logic [2:0] att_r [crt_pkg::SLOTS];
  logic [crt_pkg::TIMER_BITS-1:0] tmr_r [crt_pkg::SLOTS];
  logic [1:0] c_r;
  logic [15:0] tid_r;
  logic con_r;
  logic found_r;
  logic [crt_pkg::SLOT_W-1:0] fidx_r;

  logic [crt_pkg::SLOT_W-1:0] i;
  logic ev;
  logic [2:0] inc;
  logic hit;
  logic tick_res;

  assign i = cmd.idx;
  assign ev = valid_r[i];
  assign inc = (att_r[i] == 3'd7) ? 3'd7 : att_r[i] + 3'd1;
  assign tick_res = cmd.scan && (c_r == crt_pkg::CMD_TICK) && hit;

  always_comb begin
    case (c_r)
      crt_pkg::CMD_OPEN: hit = !ev;
      crt_pkg::CMD_TICK: hit = ev && (tmr_r[i] <= crt_pkg::TIMER_BITS'(1));
      default: hit = ev && (id_r[i] == tid_r);
    endcase
  end

  assign sts.cmd = c_r;
  assign sts.hit = hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      out_valid <= 1'b0;
      found_r <= 1'b0;
    end else begin
      out_valid <= tick_res || cmd.finish;
      if (cmd.load) begin
        c_r <= in_command;
        tid_r <= in_trans_id;
        con_r <= in_confirmable;
        found_r <= 1'b0;
      end
      if (cmd.scan && c_r == crt_pkg::CMD_TICK && ev) begin
        if (!hit) begin
          tmr_r[i] <= tmr_r[i] - 1'b1;
        end else begin
          att_r[i] <= inc;
          out_slot <= 3'(i);
          out_out_id <= id_r[i];
          out_attempt <= inc;
          out_last <= 1'b0;
          if (inc < max_retransmit) begin
            tmr_r[i] <= crt_pkg::arm_value(base_timeout, inc);
            out_kind <= crt_pkg::K_RESEND;
          end else begin
            valid_r[i] <= 1'b0;
            out_kind <= crt_pkg::K_GIVEUP;
          end
        end
      end
      if (cmd.scan && c_r != crt_pkg::CMD_TICK && hit) begin
        found_r <= 1'b1;
        fidx_r <= i;
      end
      if (cmd.finish) begin
        out_last <= 1'b1;
        case (c_r)
          crt_pkg::CMD_TICK: begin
            out_kind <= crt_pkg::K_TICKDONE;
            out_slot <= 3'd0;
            out_out_id <= 16'd0;
            out_attempt <= 3'd0;
          end
          crt_pkg::CMD_OPEN: begin
            out_out_id <= tid_r;
            out_attempt <= 3'd0;
            if (!found_r) begin
              out_kind <= crt_pkg::K_NOSLOT_FOUND;
              out_slot <= 3'd0;
            end else begin
              out_slot <= 3'(fidx_r);
              id_r[fidx_r] <= tid_r;
              att_r[fidx_r] <= 3'd0;
              if (con_r && max_retransmit != 3'd0) begin
                valid_r[fidx_r] <= 1'b1;
                tmr_r[fidx_r] <= crt_pkg::arm_value(base_timeout, 3'd0);
                out_kind <= crt_pkg::K_KEPT;
              end else if (con_r) begin
                out_kind <= crt_pkg::K_GIVEUP;
              end else begin
                out_kind <= crt_pkg::K_ONCE;
              end
            end
          end
          default: begin
            if (!found_r) begin
              out_kind <= crt_pkg::K_NOTFOUND;
              out_slot <= 3'd0;
              out_out_id <= tid_r;
              out_attempt <= 3'd0;
            end else begin
              out_slot <= 3'(fidx_r);
              out_out_id <= id_r[fidx_r];
              out_attempt <= att_r[fidx_r];
              if (c_r == crt_pkg::CMD_CLEAR) begin
                valid_r[fidx_r] <= 1'b0;
                out_kind <= crt_pkg::K_CLEARED;
              end else begin
                out_kind <= crt_pkg::K_NOSLOT_FOUND;
              end
            end
          end
        endcase
      end
    end
  end
endmodule

### rtl/core/confirmable_retransmit_table.sv
// open, clear and lookup stop the walk at the first matching slot, tick walks every slot
// throughput: one command at a time, a sequencer walks one slot per cycle
// a tick gives one result per expired slot during the walk, then tick done
// results are strobed for one cycle, the receiver cannot stall
// synchronous reset empties the table and restores the register defaults
module confirmable_retransmit_table (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [1:0] in_command,
  input  logic [15:0] in_trans_id,
  input  logic in_confirmable,
  output logic out_valid,
  output logic [2:0] out_kind,
  output logic [2:0] out_slot,
  output logic [15:0] out_out_id,
  output logic [2:0] out_attempt,
  output logic out_last,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [15:0] base_r;
  logic [2:0] maxrt_r;
  logic wr;
  crt_pkg::crt_cmd_t cmd;
  crt_pkg::crt_sts_t sts;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && (paddr[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= crt_pkg::BASE_RESET;
      maxrt_r <= crt_pkg::MAXRT_RESET;
    end else if (wr) begin
      if (paddr[2] == crt_pkg::REG_BASE) base_r <= pwdata[15:0];
      else if (paddr[2] == crt_pkg::REG_MAXRT) maxrt_r <= pwdata[2:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == crt_pkg::REG_BASE) prdata = {16'd0, base_r};
      else prdata = {29'd0, maxrt_r};
    end
  end

  crt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  crt_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_command(in_command), .in_trans_id(in_trans_id),
    .in_confirmable(in_confirmable),
    .base_timeout(base_r), .max_retransmit(maxrt_r),
    .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_kind(out_kind), .out_slot(out_slot),
    .out_out_id(out_out_id), .out_attempt(out_attempt), .out_last(out_last)
  );
endmodule
